>>> rtl/gtle_pkg.sv
package gtle_pkg;

    typedef logic signed [63:0] t_q61;

    typedef enum logic [1:0] {
        CFG_HOME_LON = 2'd0,
        CFG_HOME_LAT = 2'd1,
        CFG_HOME_ALT = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int NEWTON_STEPS = 5;

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam t_q61 ONE_Q61       = 64'sh2000000000000000;
    localparam t_q61 THREE_Q61     = 64'sh6000000000000000;
    localparam logic [63:0] DEG7_U = (PI_Q61 + 64'd900000000) / 64'd1800000000;
    localparam logic signed [32:0] DEG7_TO_RAD = {1'b0, DEG7_U[31:0]};
    localparam t_q61 GAIN_INV_Q61   = 64'sd1400229935014726476;
    localparam t_q61 E2_Q61         = 64'sd15436189301287400;
    localparam t_q61 SEMI_MAJOR_Q16 = 64'sd6378137000 * 64'sd65536;
    localparam t_q61 OUT_LIMIT      = 64'sd13000000000;
    localparam t_q61 ROUND_Q16      = 64'sd32768;

    // input range bounds
    localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;
    localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
    localparam logic signed [31:0] ALT_MIN   = -32'sd3000000;
    localparam logic signed [31:0] ALT_MAX   = 32'sd10000000;

    // angle wrap and fold
    localparam logic signed [33:0] ANG_HALF    = 34'sd1800000000;
    localparam logic signed [33:0] ANG_FULL    = 34'sd3600000000;
    localparam logic signed [33:0] ANG_QUARTER = 34'sd900000000;

    function automatic logic [63:0] pow2_div(input int e, input int d);
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rem;
        num = 64'd1 << e;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(d)) begin
                rem = rem - 64'(d);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_q61 atan_entry(input int i);
        t_q61 sum;
        int e;
        logic [63:0] term;
        sum = '0;
        if (i == 0) begin
            sum = $signed(PI_Q61 >> 2);
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = 61 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = pow2_div(e, 2 * k + 1);
                    if (k[0]) begin
                        sum = sum - $signed(term);
                    end else begin
                        sum = sum + $signed(term);
                    end
                end
            end
        end
        return sum;
    endfunction

endpackage

>>> rtl/gtle_in_if.sv
interface gtle_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_longitude;
    logic signed [31:0] point_latitude;
    logic signed [31:0] point_altitude;

    modport source (
        output valid, point_longitude, point_latitude, point_altitude,
        input  ready
    );
    modport sink (
        input  valid, point_longitude, point_latitude, point_altitude,
        output ready
    );
endinterface

>>> rtl/gtle_out_if.sv
interface gtle_out_if;
    logic               valid;
    logic               ready;
    logic signed [34:0] east_offset;
    logic signed [34:0] north_offset;
    logic signed [34:0] up_offset;
    logic               valid_res;

    modport source (
        output valid, east_offset, north_offset, up_offset, valid_res,
        input  ready
    );
    modport sink (
        input  valid, east_offset, north_offset, up_offset, valid_res,
        output ready
    );
endinterface

>>> rtl/gtle_dly.sv
module gtle_dly #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];
endmodule

>>> rtl/gtle_mulq.sv
module gtle_mulq (
    input  logic           i_clk,
    input  logic           i_en,
    input  gtle_pkg::t_q61 i_a,
    input  gtle_pkg::t_q61 i_b,
    output gtle_pkg::t_q61 o_p
);
    import gtle_pkg::*;

    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic         r_neg0;
    logic         r_neg1;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    t_q61         r_p;
    logic [127:0] w_sum;
    logic [62:0]  w_mag;

    // abs, partial products, then sum with round half away from zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua   <= i_a[63] ? 64'(-i_a) : i_a;
            r_ub   <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg0 <= i_a[63] ^ i_b[63];
            r_p00  <= r_ua[31:0] * r_ub[31:0];
            r_p01  <= r_ua[31:0] * r_ub[63:32];
            r_p10  <= r_ua[63:32] * r_ub[31:0];
            r_p11  <= r_ua[63:32] * r_ub[63:32];
            r_neg1 <= r_neg0;
            r_p    <= r_neg1 ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign w_sum = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                 + {64'd0, r_p00} + (128'd1 << 60);
    assign w_mag = w_sum[123:61];
    assign o_p   = r_p;
endmodule

>>> rtl/gtle_sincos.sv
module gtle_sincos #(
    parameter int STEPS = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_ang,
    output gtle_pkg::t_q61     o_sin,
    output gtle_pkg::t_q61     o_cos
);
    import gtle_pkg::*;

    logic signed [33:0] w_ext;
    logic signed [33:0] w_wrap;
    logic signed [33:0] w_fold;
    logic               w_flip;
    logic signed [30:0] r_a;
    logic               r_flip_a;
    t_q61               w_z0;
    t_q61               r_x0;
    t_q61               r_y0;
    t_q61               r_z0;
    logic               r_f0;
    t_q61               w_x [STEPS+1];
    t_q61               w_y [STEPS+1];
    t_q61               w_z [STEPS+1];
    logic               w_f [STEPS+1];
    t_q61               r_sin;
    t_q61               r_cos;

    always_comb begin
        w_ext  = 34'(i_ang);
        w_flip = 1'b0;
        if (w_ext > ANG_HALF) begin
            w_wrap = w_ext - ANG_FULL;
        end else if (w_ext < -ANG_HALF) begin
            w_wrap = w_ext + ANG_FULL;
        end else begin
            w_wrap = w_ext;
        end
        if (w_wrap > ANG_QUARTER) begin
            w_fold = ANG_HALF - w_wrap;
            w_flip = 1'b1;
        end else if (w_wrap < -ANG_QUARTER) begin
            w_fold = -ANG_HALF - w_wrap;
            w_flip = 1'b1;
        end else begin
            w_fold = w_wrap;
        end
    end

    assign w_z0 = r_a * DEG7_TO_RAD;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= w_fold[30:0];
            r_flip_a <= w_flip;
            r_x0     <= GAIN_INV_Q61;
            r_y0     <= '0;
            r_z0     <= w_z0;
            r_f0     <= r_flip_a;
        end
    end

    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;
    assign w_f[0] = r_f0;

    for (genvar g = 0; g < STEPS; g++) begin : g_stage
        localparam t_q61 ATAN = atan_entry(g);
        t_q61 r_x;
        t_q61 r_y;
        t_q61 r_z;
        logic r_f;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[g][63]) begin
                    r_x <= w_x[g] - (w_y[g] >>> g);
                    r_y <= w_y[g] + (w_x[g] >>> g);
                    r_z <= w_z[g] - ATAN;
                end else begin
                    r_x <= w_x[g] + (w_y[g] >>> g);
                    r_y <= w_y[g] - (w_x[g] >>> g);
                    r_z <= w_z[g] + ATAN;
                end
                r_f <= w_f[g];
            end
        end

        assign w_x[g+1] = r_x;
        assign w_y[g+1] = r_y;
        assign w_z[g+1] = r_z;
        assign w_f[g+1] = r_f;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= w_y[STEPS];
            r_cos <= w_f[STEPS] ? -w_x[STEPS] : w_x[STEPS];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

>>> rtl/gtle_ecef.sv
module gtle_ecef #(
    parameter int STEPS = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_lon,
    input  logic signed [31:0] i_lat,
    input  logic signed [31:0] i_alt,
    output gtle_pkg::t_q61     o_px,
    output gtle_pkg::t_q61     o_py,
    output gtle_pkg::t_q61     o_pz,
    output gtle_pkg::t_q61     o_slon,
    output gtle_pkg::t_q61     o_clon,
    output gtle_pkg::t_q61     o_slat,
    output gtle_pkg::t_q61     o_clat
);
    import gtle_pkg::*;

    localparam int SC_TO_N16 = 7 + 10 * NEWTON_STEPS + 3;
    localparam int ALT_DLY   = STEPS + 3 + SC_TO_N16;

    t_q61         w_slon;
    t_q61         w_clon;
    t_q61         w_slat;
    t_q61         w_clat;
    t_q61         w_m1;
    t_q61         w_m2;
    t_q61         r_w;
    t_q61         w_y [NEWTON_STEPS+1];
    t_q61         w_w [NEWTON_STEPS];
    t_q61         w_n16;
    logic [31:0]  w_alt_d;
    t_q61         w_h16;
    t_q61         w_clat_d;
    t_q61         w_q;
    t_q61         w_m3;
    logic [63:0]  w_n16_d;
    logic [63:0]  w_h16_d;
    logic [191:0] w_sc_d;
    logic [191:0] w_sc_out;
    logic [63:0]  w_clat_out;

    gtle_sincos #(.STEPS(STEPS)) u_lon (
        .i_clk, .i_en, .i_ang(i_lon), .o_sin(w_slon), .o_cos(w_clon)
    );
    gtle_sincos #(.STEPS(STEPS)) u_lat (
        .i_clk, .i_en, .i_ang(i_lat), .o_sin(w_slat), .o_cos(w_clat)
    );

    gtle_mulq u_m1 (.i_clk, .i_en, .i_a(w_slat), .i_b(w_slat), .o_p(w_m1));
    gtle_mulq u_m2 (.i_clk, .i_en, .i_a(E2_Q61), .i_b(w_m1), .o_p(w_m2));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= ONE_Q61 - w_m2;
        end
    end

    assign w_y[0] = ONE_Q61;
    assign w_w[0] = r_w;

    // newton steps for 1/sqrt(w)
    for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_newton
        t_q61        w_yy;
        logic [63:0] w_wd;
        t_q61        w_b;
        logic [63:0] w_yd;
        t_q61        w_c;
        t_q61        r_y;

        gtle_mulq u_yy (.i_clk, .i_en, .i_a(w_y[g]), .i_b(w_y[g]), .o_p(w_yy));
        gtle_dly #(.WIDTH(64), .DEPTH(3)) u_wd (.i_clk, .i_en, .i_d(w_w[g]), .o_q(w_wd));
        gtle_mulq u_wyy (.i_clk, .i_en, .i_a($signed(w_wd)), .i_b(w_yy), .o_p(w_b));
        gtle_dly #(.WIDTH(64), .DEPTH(6)) u_yd (.i_clk, .i_en, .i_d(w_y[g]), .o_q(w_yd));
        gtle_mulq u_yt (
            .i_clk, .i_en, .i_a($signed(w_yd)), .i_b(THREE_Q61 - w_b), .o_p(w_c)
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y <= (w_c + $signed({63'd0, w_c[63]})) >>> 1;
            end
        end

        assign w_y[g+1] = r_y;

        if (g < NEWTON_STEPS - 1) begin : g_wnext
            logic [63:0] w_wn;
            gtle_dly #(.WIDTH(64), .DEPTH(10)) u_wn (
                .i_clk, .i_en, .i_d(w_w[g]), .o_q(w_wn)
            );
            assign w_w[g+1] = $signed(w_wn);
        end
    end

    gtle_mulq u_n16 (
        .i_clk, .i_en, .i_a(SEMI_MAJOR_Q16), .i_b(w_y[NEWTON_STEPS]), .o_p(w_n16)
    );

    gtle_dly #(.WIDTH(32), .DEPTH(ALT_DLY)) u_alt (
        .i_clk, .i_en, .i_d(i_alt), .o_q(w_alt_d)
    );
    assign w_h16 = {{16{w_alt_d[31]}}, w_alt_d, 16'd0};

    gtle_dly #(.WIDTH(64), .DEPTH(SC_TO_N16)) u_clat (
        .i_clk, .i_en, .i_d(w_clat), .o_q(w_clat_d)
    );

    gtle_mulq u_q  (.i_clk, .i_en, .i_a(w_n16 + w_h16), .i_b(w_clat_d), .o_p(w_q));
    gtle_mulq u_m3 (.i_clk, .i_en, .i_a(w_n16), .i_b(E2_Q61), .o_p(w_m3));

    gtle_dly #(.WIDTH(64), .DEPTH(3)) u_n16d (.i_clk, .i_en, .i_d(w_n16), .o_q(w_n16_d));
    gtle_dly #(.WIDTH(64), .DEPTH(3)) u_h16d (.i_clk, .i_en, .i_d(w_h16), .o_q(w_h16_d));

    gtle_dly #(.WIDTH(192), .DEPTH(SC_TO_N16 + 3)) u_sc (
        .i_clk, .i_en, .i_d({w_slon, w_clon, w_slat}), .o_q(w_sc_d)
    );

    gtle_mulq u_px (
        .i_clk, .i_en, .i_a(w_q), .i_b($signed(w_sc_d[127:64])), .o_p(o_px)
    );
    gtle_mulq u_py (
        .i_clk, .i_en, .i_a(w_q), .i_b($signed(w_sc_d[191:128])), .o_p(o_py)
    );
    gtle_mulq u_pz (
        .i_clk, .i_en,
        .i_a($signed(w_n16_d) - w_m3 + $signed(w_h16_d)),
        .i_b($signed(w_sc_d[63:0])),
        .o_p(o_pz)
    );

    gtle_dly #(.WIDTH(192), .DEPTH(3)) u_sco (
        .i_clk, .i_en, .i_d(w_sc_d), .o_q(w_sc_out)
    );
    gtle_dly #(.WIDTH(64), .DEPTH(6)) u_clato (
        .i_clk, .i_en, .i_d(w_clat_d), .o_q(w_clat_out)
    );

    assign o_slon = $signed(w_sc_out[191:128]);
    assign o_clon = $signed(w_sc_out[127:64]);
    assign o_slat = $signed(w_sc_out[63:0]);
    assign o_clat = $signed(w_clat_out);
endmodule

>>> rtl/geodetic_to_local_enu.sv
// throughput: one request per cycle unless stalled, set by the fully pipelined cordic and multiplier chain
// a stalled result freezes every stage, so input ready drops only while the output waits
// reset clears all valid bits and sets the home point to zero; payload registers are not reset
module geodetic_to_local_enu #(
    parameter int CORDIC_STEPS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gtle_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gtle_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gtle_in_if.sink                          i_pt,
    gtle_out_if.source                       o_res
);
    import gtle_pkg::*;

    localparam int LANE_LAT = CORDIC_STEPS + 69;
    localparam int LAT      = LANE_LAT + 10;

    typedef struct packed {
        logic signed [34:0] val;
        logic               sat;
    } t_fin;

    function automatic t_fin finish_mm(input t_q61 v);
        t_fin f;
        t_q61 r;
        r = (v + ROUND_Q16) >>> 16;
        f.sat = 1'b0;
        if (r > OUT_LIMIT) begin
            r = OUT_LIMIT;
            f.sat = 1'b1;
        end
        if (r < -OUT_LIMIT) begin
            r = -OUT_LIMIT;
            f.sat = 1'b1;
        end
        f.val = r[34:0];
        return f;
    endfunction

    logic signed [31:0] r_home_lon;
    logic signed [30:0] r_home_lat;
    logic signed [24:0] r_home_alt;
    logic [LAT-1:0]     r_vld;
    logic [LAT-2:0]     r_bad;
    logic               w_adv;
    logic               w_acc;
    logic               w_bad;
    t_q61 w_ppx, w_ppy, w_ppz, w_pslon, w_pclon, w_pslat, w_pclat;
    t_q61 w_hpx, w_hpy, w_hpz, w_hslon, w_hclon, w_hslat, w_hclat;
    t_q61 r_dx, r_dy, r_dz;
    logic [127:0] w_hlon_d;
    logic [127:0] w_hlat_d;
    t_q61 w_t1, w_t2, w_e1, w_e2;
    t_q61 r_t, r_e;
    logic [63:0] w_dz_d;
    t_q61 w_n1, w_n2, w_u1, w_u2;
    t_q61 r_n, r_u;
    logic [63:0] w_e_d;
    t_fin w_fe, w_fn, w_fu;
    logic signed [34:0] r_east;
    logic signed [34:0] r_north;
    logic signed [34:0] r_up;
    logic               r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_lon <= '0;
            r_home_lat <= '0;
            r_home_alt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOME_LON: begin
                    r_home_lon <= i_cfg_data;
                end
                CFG_HOME_LAT: begin
                    r_home_lat <= i_cfg_data[30:0];
                end
                CFG_HOME_ALT: begin
                    r_home_alt <= i_cfg_data[24:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_adv      = !r_vld[LAT-1] || o_res.ready;
    assign i_pt.ready = w_adv;
    assign w_acc      = i_pt.valid && w_adv;

    assign w_bad = (i_pt.point_longitude < -LON_LIMIT) || (i_pt.point_longitude > LON_LIMIT)
                || (i_pt.point_latitude < -LAT_LIMIT) || (i_pt.point_latitude > LAT_LIMIT)
                || (i_pt.point_altitude < ALT_MIN) || (i_pt.point_altitude > ALT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bad <= {r_bad[LAT-3:0], w_bad};
        end
    end

    gtle_ecef #(.STEPS(CORDIC_STEPS)) u_pt (
        .i_clk, .i_en(w_adv),
        .i_lon(i_pt.point_longitude), .i_lat(i_pt.point_latitude),
        .i_alt(i_pt.point_altitude),
        .o_px(w_ppx), .o_py(w_ppy), .o_pz(w_ppz),
        .o_slon(w_pslon), .o_clon(w_pclon), .o_slat(w_pslat), .o_clat(w_pclat)
    );

    gtle_ecef #(.STEPS(CORDIC_STEPS)) u_home (
        .i_clk, .i_en(w_adv),
        .i_lon(r_home_lon), .i_lat({r_home_lat[30], r_home_lat}),
        .i_alt({{7{r_home_alt[24]}}, r_home_alt}),
        .o_px(w_hpx), .o_py(w_hpy), .o_pz(w_hpz),
        .o_slon(w_hslon), .o_clon(w_hclon), .o_slat(w_hslat), .o_clat(w_hclat)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= w_ppx - w_hpx;
            r_dy <= w_ppy - w_hpy;
            r_dz <= w_ppz - w_hpz;
        end
    end

    gtle_dly #(.WIDTH(128), .DEPTH(1)) u_hlon (
        .i_clk, .i_en(w_adv), .i_d({w_hslon, w_hclon}), .o_q(w_hlon_d)
    );
    gtle_dly #(.WIDTH(128), .DEPTH(5)) u_hlat (
        .i_clk, .i_en(w_adv), .i_d({w_hslat, w_hclat}), .o_q(w_hlat_d)
    );

    gtle_mulq u_t1 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlon_d[63:0])),
                    .i_b(r_dx), .o_p(w_t1));
    gtle_mulq u_t2 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlon_d[127:64])),
                    .i_b(r_dy), .o_p(w_t2));
    gtle_mulq u_e1 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlon_d[63:0])),
                    .i_b(r_dy), .o_p(w_e1));
    gtle_mulq u_e2 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlon_d[127:64])),
                    .i_b(r_dx), .o_p(w_e2));

    gtle_dly #(.WIDTH(64), .DEPTH(4)) u_dz (
        .i_clk, .i_en(w_adv), .i_d(r_dz), .o_q(w_dz_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t <= w_t1 + w_t2;
            r_e <= w_e1 - w_e2;
        end
    end

    gtle_mulq u_n1 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlat_d[63:0])),
                    .i_b($signed(w_dz_d)), .o_p(w_n1));
    gtle_mulq u_n2 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlat_d[127:64])),
                    .i_b(r_t), .o_p(w_n2));
    gtle_mulq u_u1 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlat_d[63:0])),
                    .i_b(r_t), .o_p(w_u1));
    gtle_mulq u_u2 (.i_clk, .i_en(w_adv), .i_a($signed(w_hlat_d[127:64])),
                    .i_b($signed(w_dz_d)), .o_p(w_u2));

    gtle_dly #(.WIDTH(64), .DEPTH(4)) u_ed (
        .i_clk, .i_en(w_adv), .i_d(r_e), .o_q(w_e_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n <= w_n1 - w_n2;
            r_u <= w_u1 + w_u2;
        end
    end

    assign w_fe = finish_mm($signed(w_e_d));
    assign w_fn = finish_mm(r_n);
    assign w_fu = finish_mm(r_u);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_east  <= r_bad[LAT-2] ? '0 : w_fe.val;
            r_north <= r_bad[LAT-2] ? '0 : w_fn.val;
            r_up    <= r_bad[LAT-2] ? '0 : w_fu.val;
            r_ok    <= !r_bad[LAT-2] && !w_fe.sat && !w_fn.sat && !w_fu.sat;
        end
    end

    assign o_res.valid        = r_vld[LAT-1];
    assign o_res.east_offset  = r_east;
    assign o_res.north_offset = r_north;
    assign o_res.up_offset    = r_up;
    assign o_res.valid_res    = r_ok;

    localparam logic signed [34:0] LIM = OUT_LIMIT[34:0];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_pt.ready)
        else $error("input taken while result stalled");

    a_reject_zero_or_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.valid_res |->
            (o_res.east_offset == 0 && o_res.north_offset == 0 && o_res.up_offset == 0)
            || o_res.east_offset == LIM || o_res.east_offset == -LIM
            || o_res.north_offset == LIM || o_res.north_offset == -LIM
            || o_res.up_offset == LIM || o_res.up_offset == -LIM)
        else $error("invalid result neither zero nor saturated");
endmodule

>>> tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gtle_pkg::*;

    localparam int STEPS = 32;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int PHASE_POINTS = 250;
    localparam int NUM_PHASES = 7;
    localparam int DRAIN_CYCLES = STEPS + 79 + 20;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [34:0] east;
        logic signed [34:0] north;
        logic signed [34:0] up;
        logic               good;
    } t_enu;

    typedef struct {
        int     lon;
        int     lat;
        int     alt;
        bit     known;
        t_enu   res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    gtle_in_if  pt_if ();
    gtle_out_if res_if ();

    geodetic_to_local_enu #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if.sink),
        .o_res      (res_if.source)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of the home registers
    logic [31:0] home_lon;
    logic [30:0] home_lat;
    logic [24:0] home_alt;
    longint atan_q61 [STEPS];

    t_enu pending_enu [$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    function automatic longint mul_q61(longint a, longint b);
        bit neg;
        bit [63:0] ua, ub;
        bit [127:0] p;
        longint r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = {64'b0, ua} * {64'b0, ub};
        p = p + (128'd1 << 60);
        r = {1'b0, p[123:61]};
        return neg ? -r : r;
    endfunction

    function automatic void build_atan();
        longint sum;
        int e;
        atan_q61[0] = longint'(PI_Q61 >> 2);
        for (int i = 1; i < STEPS; i++) begin
            sum = 0;
            for (int k = 0; k < 64; k++) begin
                e = 61 - i * (2 * k + 1);
                if (e >= 0) begin
                    if (k % 2 == 1) sum -= longint'((64'd1 << e) / (2 * k + 1));
                    else sum += longint'((64'd1 << e) / (2 * k + 1));
                end
            end
            atan_q61[i] = sum;
        end
    endfunction

    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit flip;
        x = GAIN_INV_Q61;
        y = 0;
        flip = 0;
        if (ang > 1800000000) ang -= 64'sd3600000000;
        else if (ang < -1800000000) ang += 64'sd3600000000;
        if (ang > 900000000) begin
            ang = 1800000000 - ang;
            flip = 1;
        end else if (ang < -900000000) begin
            ang = -1800000000 - ang;
            flip = 1;
        end
        z = ang * longint'(DEG7_U);
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_q61[i];
            end else begin
                x += dx; y -= dy; z += atan_q61[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    task automatic to_ecef(input longint lon, input longint lat, input longint alt,
                           output longint px, output longint py, output longint pz,
                           output longint slon, output longint clon,
                           output longint slat, output longint clat);
        longint w, y, t, n16, h16, q;
        sin_cos(lon, slon, clon);
        sin_cos(lat, slat, clat);
        w = ONE_Q61 - mul_q61(E2_Q61, mul_q61(slat, slat));
        y = ONE_Q61;
        for (int i = 0; i < 5; i++) begin
            t = THREE_Q61 - mul_q61(w, mul_q61(y, y));
            y = mul_q61(y, t) / 2;
        end
        n16 = mul_q61(SEMI_MAJOR_Q16, y);
        h16 = alt * 65536;
        q = mul_q61(n16 + h16, clat);
        px = mul_q61(q, clon);
        py = mul_q61(q, slon);
        pz = mul_q61(n16 - mul_q61(n16, E2_Q61) + h16, slat);
    endtask

    function automatic longint round_mm(longint v16, ref bit good);
        longint v;
        v = (v16 + ROUND_Q16) >>> 16;
        if (v > OUT_LIMIT) begin v = OUT_LIMIT; good = 0; end
        if (v < -OUT_LIMIT) begin v = -OUT_LIMIT; good = 0; end
        return v;
    endfunction

    task automatic predict_enu(input int lon, input int lat, input int alt, output t_enu r);
        longint ax, ay, az, bx, by, bz, s0, c0, s1, c1, hs0, hc0, hs1, hc1;
        longint dx, dy, dz, t, e, n, u;
        bit good;
        good = 1;
        if (lon < -1800000000 || lon > 1800000000 || lat < -900000000 || lat > 900000000 ||
            alt < -3000000 || alt > 10000000) begin
            r = '{0, 0, 0, 1'b0};
        end else begin
            to_ecef(lon, lat, alt, ax, ay, az, s0, c0, s1, c1);
            to_ecef(longint'($signed(home_lon)), longint'($signed(home_lat)),
                    longint'($signed(home_alt)), bx, by, bz, hs0, hc0, hs1, hc1);
            dx = ax - bx;
            dy = ay - by;
            dz = az - bz;
            t = mul_q61(hc0, dx) + mul_q61(hs0, dy);
            e = mul_q61(hc0, dy) - mul_q61(hs0, dx);
            n = mul_q61(hc1, dz) - mul_q61(hs1, t);
            u = mul_q61(hc1, t) + mul_q61(hs1, dz);
            r.east  = 35'(round_mm(e, good));
            r.north = 35'(round_mm(n, good));
            r.up    = 35'(round_mm(u, good));
            r.good  = good;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_HOME_LON: home_lon = data;
            CFG_HOME_LAT: home_lat = data[30:0];
            CFG_HOME_ALT: home_alt = data[24:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_home(input logic [31:0] lon, input logic [31:0] lat,
                             input logic [31:0] alt);
        write_reg(CFG_HOME_LON, lon);
        write_reg(CFG_HOME_LAT, lat);
        write_reg(CFG_HOME_ALT, alt);
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_point(input int lon, input int lat, input int alt,
                              input bit known, input t_enu typed);
        t_enu r;
        if (known) r = typed;
        else predict_enu(lon, lat, alt, r);
        while ($urandom_range(99) < idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid           <= 1'b1;
        pt_if.point_longitude <= lon;
        pt_if.point_latitude  <= lat;
        pt_if.point_altitude  <= alt;
        do @(posedge i_clk); while (!pt_if.ready);
        pending_enu.push_back(r);
    endtask

    function automatic int pick_in(int lo, int hi);
        return int'(longint'(lo) + longint'($urandom_range(32'(longint'(hi) - lo))));
    endfunction

    task automatic random_point();
        int lon, lat, alt, k;
        t_enu none;
        none = '{0, 0, 0, 1'b0};
        k = $urandom_range(99);
        if (k < 12) begin
            send_point($urandom, $urandom, $urandom, 0, none);
        end else if (k < 20) begin
            // one field just past its bound
            lon = pick_in(-1800000000, 1800000000);
            lat = pick_in(-900000000, 900000000);
            alt = pick_in(-3000000, 10000000);
            case ($urandom_range(5))
                0: lon = 1800000000 + $urandom_range(1, 1000);
                1: lon = -1800000000 - $urandom_range(1, 1000);
                2: lat = 900000000 + $urandom_range(1, 1000);
                3: lat = -900000000 - $urandom_range(1, 1000);
                4: alt = 10000000 + $urandom_range(1, 1000);
                default: alt = -3000000 - $urandom_range(1, 1000);
            endcase
            send_point(lon, lat, alt, 0, none);
        end else if (k < 45) begin
            // near the home point
            lon = int'($signed(home_lon)) + pick_in(-200000, 200000);
            lat = int'($signed(home_lat)) + pick_in(-200000, 200000);
            alt = pick_in(-3000000, 10000000);
            if (lon > 1800000000 || lon < -1800000000) lon = 0;
            if (lat > 900000000 || lat < -900000000) lat = 0;
            send_point(lon, lat, alt, 0, none);
        end else begin
            lon = pick_in(-1800000000, 1800000000);
            lat = pick_in(-900000000, 900000000);
            alt = pick_in(-3000000, 10000000);
            if ($urandom_range(9) == 0) lon = $urandom_range(1) ? 1800000000 : -1800000000;
            if ($urandom_range(9) == 0) lat = $urandom_range(1) ? 900000000 : -900000000;
            if ($urandom_range(9) == 0) alt = $urandom_range(1) ? 10000000 : -3000000;
            send_point(lon, lat, alt, 0, none);
        end
    endtask

    task automatic drain();
        pt_if.valid <= 1'b0;
        while (pending_enu.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // result check, receiver stalls and watchdog
    always @(posedge i_clk) begin
        t_enu want;
        if (res_if.valid && res_if.ready) begin
            if (pending_enu.size() == 0) begin
                $error("unexpected result east=%0d north=%0d up=%0d valid_res=%0b",
                       res_if.east_offset, res_if.north_offset, res_if.up_offset,
                       res_if.valid_res);
                errors++;
            end else begin
                want = pending_enu.pop_front();
                if (res_if.east_offset !== want.east) begin
                    $error("east_offset expected %0d actual %0d", want.east,
                           res_if.east_offset);
                    errors++;
                end
                if (res_if.north_offset !== want.north) begin
                    $error("north_offset expected %0d actual %0d", want.north,
                           res_if.north_offset);
                    errors++;
                end
                if (res_if.up_offset !== want.up) begin
                    $error("up_offset expected %0d actual %0d", want.up, res_if.up_offset);
                    errors++;
                end
                if (res_if.valid_res !== want.good) begin
                    $error("valid_res expected %0b actual %0b", want.good, res_if.valid_res);
                    errors++;
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= stall_pct);
        if (!i_rst_n || (res_if.valid && res_if.ready) || (pt_if.valid && pt_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    t_row directed [] = '{
        '{0, 0, 0, 1, '{0, 0, 0, 1'b1}},
        '{1800000001, 0, 0, 1, '{0, 0, 0, 1'b0}},
        '{-1800000001, 0, 0, 1, '{0, 0, 0, 1'b0}},
        '{0, 900000001, 0, 1, '{0, 0, 0, 1'b0}},
        '{0, -900000001, 0, 1, '{0, 0, 0, 1'b0}},
        '{0, 0, -3000001, 1, '{0, 0, 0, 1'b0}},
        '{0, 0, 10000001, 1, '{0, 0, 0, 1'b0}},
        '{32'h80000000, 32'h80000000, 32'h80000000, 1, '{0, 0, 0, 1'b0}},
        '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, '{0, 0, 0, 1'b0}},
        '{1800000000, 0, 0, 0, '{0, 0, 0, 1'b0}},
        '{-1800000000, 0, 0, 0, '{0, 0, 0, 1'b0}},
        '{0, 900000000, 0, 0, '{0, 0, 0, 1'b0}},
        '{0, -900000000, 0, 0, '{0, 0, 0, 1'b0}},
        '{0, 0, -3000000, 0, '{0, 0, 0, 1'b0}},
        '{0, 0, 10000000, 0, '{0, 0, 0, 1'b0}},
        '{900000000, 0, 0, 0, '{0, 0, 0, 1'b0}},
        '{-900000000, 450000000, 5000000, 0, '{0, 0, 0, 1'b0}},
        '{1800000000, 900000000, 10000000, 0, '{0, 0, 0, 1'b0}},
        '{-1800000000, -900000000, -3000000, 0, '{0, 0, 0, 1'b0}},
        '{1, 1, 1, 0, '{0, 0, 0, 1'b0}},
        '{-1, -1, -1, 0, '{0, 0, 0, 1'b0}}
    };

    initial begin
        logic [31:0] hl, ht, ha;
        build_atan();
        home_lon = '0;
        home_lat = '0;
        home_alt = '0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        pt_if.valid <= 1'b0;
        pt_if.point_longitude <= '0;
        pt_if.point_latitude <= '0;
        pt_if.point_altitude <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_point(directed[i].lon, directed[i].lat, directed[i].alt,
                       directed[i].known, directed[i].res);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin hl = 1800000000; ht = 900000000; ha = 10000000; end
                1: begin hl = -1800000000; ht = -900000000; ha = -3000000; end
                2: begin hl = 32'h7fffffff; ht = 32'h3fffffff; ha = 32'h00ffffff; end
                3: begin hl = 32'h80000000; ht = 32'hc0000000; ha = 32'hff000000; end
                default: begin
                    hl = pick_in(-1800000000, 1800000000);
                    ht = pick_in(-900000000, 900000000);
                    ha = pick_in(-3000000, 10000000);
                end
            endcase
            load_home(hl, ht, ha);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < PHASE_POINTS; n++) random_point();
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_enu.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/gtle_pkg.sv
rtl/gtle_in_if.sv
rtl/gtle_out_if.sv
rtl/gtle_dly.sv
rtl/gtle_mulq.sv
rtl/gtle_sincos.sv
rtl/gtle_ecef.sv
rtl/geodetic_to_local_enu.sv
tb/sv/tb.sv
